// File: rtl/core/ccp_pkg.sv
// Shared types and constants for the coefficient compress and pack block.
package ccp_pkg;

  // Field widths.
  localparam int COEFF_W = 14;
  localparam int WIDTH_W = 4;
  localparam int CODE_W  = 7;
  localparam int BYTE_W  = 8;
  localparam int ACC_W   = 21;
  localparam int CNT_W   = 5;

  // Divider sizing: numerator is (x << width) + q/2 with width up to 7, two quotient bits per cycle.
  localparam int NUM_W     = 22;
  localparam int DIV_STEPS = NUM_W / 2;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Format codes.
  localparam logic [1:0] FMT_MSG   = 2'd0;
  localparam logic [1:0] FMT_THREE = 2'd1;
  localparam logic [1:0] FMT_SEVEN = 2'd2;
  localparam logic [1:0] FMT_RAW   = 2'd3;

  // One classified coefficient waiting for the back end.
  typedef struct packed {
    logic [COEFF_W-1:0] coeff;
    logic [WIDTH_W-1:0] width;
    logic               raw;
    logic [COEFF_W-1:0] divisor;
    logic               last;
  } queue_item_t;

  // Divider request and response.
  typedef struct packed {
    logic               start;
    logic [NUM_W-1:0]   numerator;
    logic [COEFF_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [CODE_W-1:0] quotient;
  } div_rsp_t;

  // One output byte with its flags.
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              run_last;
    logic              poly_end;
  } out_entry_t;

endpackage

// File: rtl/core/ccp_front.sv
// Front end: configuration registers, input acceptance and classification.
module ccp_front #(
  parameter int COEFF_COUNT = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic [ccp_pkg::COEFF_W-1:0] coefficient,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       queue_full,
  output logic                       queue_push,
  output ccp_pkg::queue_item_t       queue_item
);

  localparam int IDX_W = $clog2(COEFF_COUNT);
  localparam logic REG_MODULUS = 1'b0;
  localparam logic REG_FORMAT  = 1'b1;

  logic [ccp_pkg::COEFF_W-1:0] modulus;
  logic [1:0]                  format;
  logic [IDX_W-1:0]            coeff_index;
  logic                        cfg_write;
  logic                        last;

  // Register port: always ready, one word per register.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= ccp_pkg::COEFF_W'(3329);
      format  <= ccp_pkg::FMT_THREE;
    end else if (cfg_write) begin
      if (paddr[2] == REG_MODULUS) begin
        modulus <= pwdata[ccp_pkg::COEFF_W-1:0];
      end else begin
        format <= pwdata[1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_FORMAT) begin
      prdata = {30'd0, format};
    end else begin
      prdata = {{(32 - ccp_pkg::COEFF_W){1'b0}}, modulus};
    end
  end

  // Input transfer goes straight into the queue.
  assign in_stall   = queue_full;
  assign queue_push = in_valid && !queue_full;
  assign last       = (coeff_index == IDX_W'(COEFF_COUNT - 1));

  // Position of the next coefficient within the polynomial.
  always_ff @(posedge clk) begin
    if (rst) begin
      coeff_index <= '0;
    end else if (queue_push) begin
      if (last) begin
        coeff_index <= '0;
      end else begin
        coeff_index <= coeff_index + 1'b1;
      end
    end
  end

  // Classify the coefficient under the format in force now.
  always_comb begin
    queue_item.coeff   = coefficient;
    queue_item.last    = last;
    queue_item.divisor = (modulus == '0) ? ccp_pkg::COEFF_W'(1) : modulus;
    queue_item.raw     = 1'b0;
    case (format)
      ccp_pkg::FMT_MSG:   queue_item.width = ccp_pkg::WIDTH_W'(1);
      ccp_pkg::FMT_THREE: queue_item.width = ccp_pkg::WIDTH_W'(3);
      ccp_pkg::FMT_SEVEN: queue_item.width = ccp_pkg::WIDTH_W'(7);
      default: begin
        queue_item.width = ccp_pkg::WIDTH_W'(ccp_pkg::COEFF_W);
        queue_item.raw   = 1'b1;
      end
    endcase
  end

endmodule

// File: rtl/core/ccp_fifo.sv
// Short queue of classified coefficients between front and back.
module ccp_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  ccp_pkg::queue_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output ccp_pkg::queue_item_t head,
  output logic                 empty
);

  ccp_pkg::queue_item_t              entries [ccp_pkg::QUEUE_DEPTH];
  logic [ccp_pkg::QPTR_W-1:0]        wr_ptr;
  logic [ccp_pkg::QPTR_W-1:0]        rd_ptr;
  logic [ccp_pkg::QCNT_W-1:0]        count;

  assign full  = (count == ccp_pkg::QCNT_W'(ccp_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

// File: rtl/core/ccp_divider.sv
// Radix-4 restoring divider giving the low quotient bits of the compression.
module ccp_divider (
  input  logic              clk,
  input  logic              rst,
  input  ccp_pkg::div_req_t req,
  output ccp_pkg::div_rsp_t rsp
);

  logic                          busy;
  logic                          done;
  logic [ccp_pkg::STEP_W-1:0]    step;
  logic [ccp_pkg::NUM_W-1:0]     num;
  logic [ccp_pkg::COEFF_W-1:0]   rem;
  logic [ccp_pkg::COEFF_W-1:0]   divisor;
  logic [ccp_pkg::CODE_W-1:0]    quo;
  logic [ccp_pkg::COEFF_W:0]     r1;
  logic [ccp_pkg::COEFF_W:0]     r1s;
  logic [ccp_pkg::COEFF_W:0]     r2;
  logic [ccp_pkg::COEFF_W:0]     r2s;
  logic                          ge1;
  logic                          ge2;

  // Two dependent shift-compare-subtract steps per cycle.
  always_comb begin
    r1  = {rem, num[ccp_pkg::NUM_W-1]};
    ge1 = (r1 >= {1'b0, divisor});
    r1s = ge1 ? (r1 - {1'b0, divisor}) : r1;
    r2  = {r1s[ccp_pkg::COEFF_W-1:0], num[ccp_pkg::NUM_W-2]};
    ge2 = (r2 >= {1'b0, divisor});
    r2s = ge2 ? (r2 - {1'b0, divisor}) : r2;
  end

  // Iteration control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == ccp_pkg::STEP_W'(ccp_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (req.start) begin
      num     <= req.numerator;
      divisor <= req.divisor;
      rem     <= '0;
      quo     <= '0;
    end else if (busy) begin
      num <= {num[ccp_pkg::NUM_W-3:0], 2'b00};
      rem <= r2s[ccp_pkg::COEFF_W-1:0];
      quo <= {quo[ccp_pkg::CODE_W-3:0], ge1, ge2};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// File: rtl/core/ccp_back.sv
// Back end: compression sequencing, bit packing and output byte buffer.
module ccp_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        queue_empty,
  input  ccp_pkg::queue_item_t        queue_head,
  output logic                        queue_pop,
  output logic [ccp_pkg::BYTE_W-1:0]  out_byte,
  output logic                        run_last,
  output logic                        poly_end,
  output logic                        out_valid,
  input  logic                        out_stall
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_PACK = 2'd2;

  logic [1:0]                   state;
  ccp_pkg::queue_item_t         cur;
  logic [ccp_pkg::COEFF_W-1:0]  code;
  logic [ccp_pkg::CODE_W-1:0]   acc;
  logic [2:0]                   cnt;
  ccp_pkg::out_entry_t          pend0;
  ccp_pkg::out_entry_t          pend1;
  logic [1:0]                   pend_count;
  ccp_pkg::div_req_t            div_req;
  ccp_pkg::div_rsp_t            div_rsp;
  logic [ccp_pkg::CODE_W-1:0]   code_mask;
  logic                         pack_fire;
  logic                         xfer;
  logic [ccp_pkg::ACC_W-1:0]    acc_new;
  logic [ccp_pkg::CNT_W-1:0]    cnt_new;
  logic [1:0]                   nfull;
  logic                         extra;
  logic [1:0]                   n;
  ccp_pkg::out_entry_t          e0;
  ccp_pkg::out_entry_t          e1;

  ccp_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Take the next item and start the divider unless it is raw.
  assign queue_pop         = (state == S_IDLE) && !queue_empty;
  assign div_req.start     = queue_pop && !queue_head.raw;
  assign div_req.divisor   = queue_head.divisor;
  assign div_req.numerator = (ccp_pkg::NUM_W'(queue_head.coeff) << queue_head.width)
                           + ccp_pkg::NUM_W'(queue_head.divisor >> 1);

  assign code_mask = ccp_pkg::CODE_W'((8'd1 << cur.width) - 8'd1);
  assign pack_fire = (state == S_PACK) && (pend_count == 2'd0);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (queue_pop) begin
            state <= queue_head.raw ? S_PACK : S_DIV;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            state <= S_PACK;
          end
        end
        S_PACK: begin
          if (pack_fire) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Current item and its code.
  always_ff @(posedge clk) begin
    if (queue_pop) begin
      cur <= queue_head;
      if (queue_head.raw) begin
        code <= queue_head.coeff;
      end
    end else if ((state == S_DIV) && div_rsp.done) begin
      code <= ccp_pkg::COEFF_W'(div_rsp.quotient & code_mask);
    end
  end

  // Append the code to the pending bits and split off complete bytes.
  always_comb begin
    acc_new = ccp_pkg::ACC_W'(acc) | (ccp_pkg::ACC_W'(code) << cnt);
    cnt_new = ccp_pkg::CNT_W'(cnt) + ccp_pkg::CNT_W'(cur.width);
    if (cnt_new[4]) begin
      nfull = 2'd2;
    end else if (cnt_new[3]) begin
      nfull = 2'd1;
    end else begin
      nfull = 2'd0;
    end
    // A partial byte at the end of the polynomial goes out padded with zeros, unless two full bytes already leave.
    extra = cur.last && !cnt_new[4] && (cnt_new[2:0] != 3'd0);
    n     = nfull + {1'b0, extra};
    e0.data     = acc_new[7:0];
    e0.run_last = (n == 2'd1);
    e0.poly_end = (n == 2'd1) && cur.last;
    e1.data     = acc_new[15:8];
    e1.run_last = (n == 2'd2);
    e1.poly_end = (n == 2'd2) && cur.last;
  end

  // Pending bits carried to the next coefficient.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      cnt <= '0;
    end else if (pack_fire) begin
      if (cur.last) begin
        acc <= '0;
        cnt <= '0;
      end else begin
        acc <= ccp_pkg::CODE_W'(acc_new >> {nfull, 3'b000});
        cnt <= cnt_new[2:0];
      end
    end
  end

  // Output buffer: entry zero drives the port, entry one moves up on a transfer.
  assign out_valid = (pend_count != 2'd0);
  assign xfer      = out_valid && !out_stall;
  assign out_byte  = pend0.data;
  assign run_last  = pend0.run_last;
  assign poly_end  = pend0.poly_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_count <= 2'd0;
    end else if (pack_fire) begin
      pend_count <= n;
    end else if (xfer) begin
      pend_count <= pend_count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pack_fire) begin
      pend0 <= e0;
      pend1 <= e1;
    end else if (xfer) begin
      pend0 <= pend1;
    end
  end

`ifndef ASSERT_OFF
  a_poly_end_is_run_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && poly_end |-> run_last)
    else $error("poly_end without run_last");

  a_div_done_to_pack: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) && div_rsp.done |=> (state == S_PACK))
    else $error("divider result not taken into packing");

  a_pop_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    queue_pop |=> (state != S_IDLE))
    else $error("sequencer stayed idle after taking an item");

  a_poly_end_clears: assert property (@(posedge clk) disable iff (rst)
    pack_fire && cur.last |=> (acc == '0) && (cnt == 3'd0))
    else $error("pending bits not cleared at polynomial end");
`endif

endmodule

// File: rtl/core/coefficient_compress_pack.sv
// Top level of the coefficient compress and pack block.
// Formats 0 to 2: an item goes from the queue through the divider's 11 iterations of two quotient
// bits each and then into packing; the back end takes a new item only when the last is packed.
// Raw format: items skip the divider; their rate is set by byte output.
// Output bytes leave at one per cycle while out_stall is low; a two-entry queue decouples input from work.
// Synchronous active-high reset clears counters, pending bits and queues at once.
module coefficient_compress_pack #(
  parameter int COEFF_COUNT = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic [ccp_pkg::COEFF_W-1:0] coefficient,
  input  logic                        in_valid,
  output logic                        in_stall,
  output logic [ccp_pkg::BYTE_W-1:0]  out_byte,
  output logic                        run_last,
  output logic                        poly_end,
  output logic                        out_valid,
  input  logic                        out_stall
);

  logic                 queue_full;
  logic                 queue_push;
  logic                 queue_pop;
  logic                 queue_empty;
  ccp_pkg::queue_item_t push_item;
  ccp_pkg::queue_item_t head_item;

  ccp_front #(
    .COEFF_COUNT (COEFF_COUNT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .coefficient (coefficient),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .queue_full  (queue_full),
    .queue_push  (queue_push),
    .queue_item  (push_item)
  );

  ccp_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (queue_push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (queue_pop),
    .head      (head_item),
    .empty     (queue_empty)
  );

  ccp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (queue_empty),
    .queue_head  (head_item),
    .queue_pop   (queue_pop),
    .out_byte    (out_byte),
    .run_last    (run_last),
    .poly_end    (poly_end),
    .out_valid   (out_valid),
    .out_stall   (out_stall)
  );

endmodule

// File: bench/tb_coefficient_compress_pack.sv
// Self-checking testbench for coefficient_compress_pack: a directed table, then random phases.
module tb_coefficient_compress_pack;

  localparam int COEFF_COUNT = 256;
  localparam logic [2:0] ADDR_MODULUS = 3'd0;
  localparam logic [2:0] ADDR_FORMAT = 3'd4;
  localparam int PREDICTED = -1;
  localparam int RANDOM_ITEMS = 1525;
  localparam int QUIET_TAIL = 150;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DIRECTED_ROWS = 31;

  typedef enum logic {ROW_COEFF, ROW_CONFIG} row_kind_t;

  // One row of the directed table: a register write or a coefficient transfer.
  typedef struct {
    row_kind_t   kind;
    logic [2:0]  addr;
    logic [31:0] value;
    int          n_typed;
    logic [7:0]  b0;
    logic [7:0]  b1;
  } stim_row_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [2:0]                  paddr = '0;
  logic [31:0]                 pwdata = '0;
  logic [31:0]                 prdata;
  logic                        pready;
  logic [ccp_pkg::COEFF_W-1:0] coefficient = '0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [ccp_pkg::BYTE_W-1:0]  out_byte;
  logic                        run_last;
  logic                        poly_end;
  logic                        out_valid;
  logic                        out_stall;

  // Shadow of the registers and of the packing state.
  logic [ccp_pkg::COEFF_W-1:0] cfg_modulus = 14'd3329;
  logic [1:0]                  cfg_format = ccp_pkg::FMT_THREE;
  logic [ccp_pkg::ACC_W-1:0]   acc_bits = '0;
  logic [ccp_pkg::CNT_W-1:0]   acc_count = '0;
  int                          coeff_pos = 0;
  ccp_pkg::out_entry_t         step_bytes [2];
  int                          step_count;
  ccp_pkg::out_entry_t         expected_bytes [$];

  // Run control and statistics.
  bit tx_gaps = 1'b0;
  bit rx_gaps = 1'b0;
  bit hold_off_request = 1'b0;
  int errors = 0;
  int bytes_checked = 0;
  int polys_done = 0;
  int coeffs_sent = 0;
  int phase_count = 0;
  ccp_pkg::out_entry_t oldest;
  stim_row_t directed_plan [DIRECTED_ROWS];

  coefficient_compress_pack #(.COEFF_COUNT(COEFF_COUNT)) i_dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .coefficient(coefficient),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .out_byte(out_byte),
    .run_last(run_last),
    .poly_end(poly_end),
    .out_valid(out_valid),
    .out_stall(out_stall)
  );

  always #5 clk = ~clk;

  // Compress one coefficient, append its code to the pending bits and cut out the bytes.
  function automatic void pack_coefficient(input logic [ccp_pkg::COEFF_W-1:0] x);
    int unsigned width;
    int unsigned code;
    int unsigned q;
    int unsigned acc;
    int unsigned cnt;
    logic last;
    case (cfg_format)
      ccp_pkg::FMT_MSG: width = 1;
      ccp_pkg::FMT_THREE: width = 3;
      ccp_pkg::FMT_SEVEN: width = 7;
      default: width = ccp_pkg::COEFF_W;
    endcase
    // A zero modulus divides by one.
    q = (cfg_modulus == '0) ? 32'd1 : 32'(cfg_modulus);
    if (cfg_format == ccp_pkg::FMT_RAW) code = 32'(x);
    else code = (((32'(x) << width) + (q >> 1)) / q) & ((32'd1 << width) - 1);
    acc = (32'(acc_bits) | (code << acc_count)) & 32'h1F_FFFF;
    cnt = 32'(acc_count) + width;
    last = (coeff_pos + 1) >= COEFF_COUNT;
    step_count = 0;
    while (cnt >= 8 && step_count < 2) begin
      step_bytes[step_count] = '{data: 8'(acc), run_last: 1'b0, poly_end: 1'b0};
      acc = acc >> 8;
      cnt = cnt - 8;
      step_count++;
    end
    // At the end of a polynomial the leftover bits go out padded, unless two bytes already left.
    if (last) begin
      if (cnt > 0 && step_count < 2) begin
        step_bytes[step_count] = '{data: 8'(acc), run_last: 1'b0, poly_end: 1'b0};
        step_count++;
      end
      acc = 0;
      cnt = 0;
      coeff_pos = 0;
    end else begin
      coeff_pos++;
    end
    if (step_count > 0) begin
      step_bytes[step_count-1].run_last = 1'b1;
      step_bytes[step_count-1].poly_end = last;
    end
    acc_bits = 21'(acc);
    acc_count = 5'(cnt);
  endfunction

  // Offer one coefficient, wait for its transfer and record the bytes it must cause.
  task automatic send_coefficient(input logic [ccp_pkg::COEFF_W-1:0] x, input int n_typed,
                                  input logic [7:0] b0, input logic [7:0] b1);
    ccp_pkg::out_entry_t typed;
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      coefficient <= 14'($urandom);
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid <= 1'b1;
    coefficient <= x;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    pack_coefficient(x);
    if (n_typed == PREDICTED) begin
      for (int i = 0; i < step_count; i++) expected_bytes.push_back(step_bytes[i]);
    end else begin
      for (int i = 0; i < n_typed; i++) begin
        typed.data = (i == 0) ? b0 : b1;
        typed.run_last = (i == n_typed - 1);
        typed.poly_end = 1'b0;
        expected_bytes.push_back(typed);
      end
    end
    coeffs_sent++;
    @(negedge clk);
  endtask

  // Stop offering, let every expected byte arrive, then allow for work that yields none.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One configuration transfer: setup cycle, then access cycle until pready.
  task automatic apb_transfer(input logic [2:0] addr, input logic is_write,
                              input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= is_write;
    paddr <= addr;
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
    logic [31:0] unused;
    apb_transfer(addr, 1'b1, value, unused);
    if (addr == ADDR_MODULUS) cfg_modulus = value[ccp_pkg::COEFF_W-1:0];
    else if (addr == ADDR_FORMAT) cfg_format = value[1:0];
  endtask

  // Read both registers back and compare with the shadow copies.
  task automatic check_registers();
    logic [31:0] rd;
    apb_transfer(ADDR_MODULUS, 1'b0, 32'h0, rd);
    if (rd !== {18'h0, cfg_modulus}) begin
      errors++;
      $display("%0t: modulus readback expected %0h actual %0h", $time, cfg_modulus, rd);
    end
    apb_transfer(ADDR_FORMAT, 1'b0, 32'h0, rd);
    if (rd !== {30'h0, cfg_format}) begin
      errors++;
      $display("%0t: format readback expected %0h actual %0h", $time, cfg_format, rd);
    end
  endtask

  // Output side: back-pressure in random bursts, plus one long hold-off on request.
  initial begin : receiver
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each output transfer with the oldest expected byte.
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected byte, expected none, actual %02h run_last %0b poly_end %0b",
                 $time, out_byte, run_last, poly_end);
      end else begin
        oldest = expected_bytes.pop_front();
        bytes_checked++;
        if (oldest.poly_end) polys_done++;
        if (out_byte !== oldest.data) begin
          errors++;
          $display("%0t: out_byte expected %02h actual %02h", $time, oldest.data, out_byte);
        end
        if (run_last !== oldest.run_last) begin
          errors++;
          $display("%0t: run_last expected %0b actual %0b", $time, oldest.run_last, run_last);
        end
        if (poly_end !== oldest.poly_end) begin
          errors++;
          $display("%0t: poly_end expected %0b actual %0b", $time, oldest.poly_end, poly_end);
        end
      end
    end
  end

  // Main sequence.
  initial begin : stimulus
    int random_sent;
    int length;
    int remaining;
    bit quiet;
    bit hold_done;
    bit hold_phase;
    logic [ccp_pkg::COEFF_W-1:0] q_pick;
    logic [1:0] fmt_pick;
    logic [ccp_pkg::COEFF_W-1:0] x;
    random_sent = 0;
    hold_done = 1'b0;

    // Raw rows have bytes that can be read off directly; the rest go through the predictor.
    directed_plan = '{
      '{ROW_CONFIG, ADDR_FORMAT, {30'h0, ccp_pkg::FMT_RAW}, PREDICTED, 8'h00, 8'h00},
      '{ROW_COEFF, 3'd0, 32'h3FFF, 1, 8'hFF, 8'h00},
      '{ROW_COEFF, 3'd0, 32'h3FFF, 2, 8'hFF, 8'hFF},
      '{ROW_COEFF, 3'd0, 32'h0000, 2, 8'h0F, 8'h00},
      '{ROW_COEFF, 3'd0, 32'h0000, 2, 8'h00, 8'h00},
      '{ROW_CONFIG, ADDR_FORMAT, {30'h0, ccp_pkg::FMT_MSG}, PREDICTED, 8'h00, 8'h00},
      '{ROW_COEFF, 3'd0, 32'd0, PREDICTED, 8'h00, 8'h00},
      '{ROW_COEFF, 3'd0, 32'd1665, PREDICTED, 8'h00, 8'h00},
      '{ROW_COEFF, 3'd0, 32'd16383, PREDICTED, 8'h00, 8'h00},
      '{ROW_COEFF, 3'd0, 32'd1664, PREDICTED, 8'h00, 8'h00},
      '{ROW_COEFF, 3'd0, 32'd4993, PREDICTED, 8'h00, 8'h00},
      '{ROW_COEFF, 3'd0, 32'd8322, PREDICTED, 8'h00, 8'h00},
      '{ROW_COEFF, 3'd0, 32'd1, PREDICTED, 8'h00, 8'h00},
      '{ROW_COEFF, 3'd0, 32'd3329, PREDICTED, 8'h00, 8'h00},
      '{ROW_CONFIG, ADDR_FORMAT, {30'h0, ccp_pkg::FMT_SEVEN}, PREDICTED, 8'h00, 8'h00},
      '{ROW_COEFF, 3'd0, 32'd16383, PREDICTED, 8'h00, 8'h00},
      '{ROW_COEFF, 3'd0, 32'd0, PREDICTED, 8'h00, 8'h00},
      '{ROW_COEFF, 3'd0, 32'd1664, PREDICTED, 8'h00, 8'h00},
      '{ROW_COEFF, 3'd0, 32'd8191, PREDICTED, 8'h00, 8'h00},
      '{ROW_CONFIG, ADDR_MODULUS, 32'h0, PREDICTED, 8'h00, 8'h00},
      '{ROW_COEFF, 3'd0, 32'd12345, PREDICTED, 8'h00, 8'h00},
      '{ROW_COEFF, 3'd0, 32'd16383, PREDICTED, 8'h00, 8'h00},
      '{ROW_CONFIG, ADDR_MODULUS, 32'hFFFF_C002, PREDICTED, 8'h00, 8'h00},
      '{ROW_CONFIG, ADDR_FORMAT, 32'hFFFF_FFFD, PREDICTED, 8'h00, 8'h00},
      '{ROW_COEFF, 3'd0, 32'd1, PREDICTED, 8'h00, 8'h00},
      '{ROW_COEFF, 3'd0, 32'd16383, PREDICTED, 8'h00, 8'h00},
      '{ROW_COEFF, 3'd0, 32'd0, PREDICTED, 8'h00, 8'h00},
      '{ROW_CONFIG, ADDR_MODULUS, 32'h3FFF, PREDICTED, 8'h00, 8'h00},
      '{ROW_COEFF, 3'd0, 32'd8191, PREDICTED, 8'h00, 8'h00},
      '{ROW_COEFF, 3'd0, 32'd16383, PREDICTED, 8'h00, 8'h00},
      '{ROW_COEFF, 3'd0, 32'd0, PREDICTED, 8'h00, 8'h00}
    };

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Directed part with light idling on both sides.
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_CONFIG) begin
        settle_block();
        write_register(directed_plan[i].addr, directed_plan[i].value);
        check_registers();
      end else begin
        send_coefficient(directed_plan[i].value[ccp_pkg::COEFF_W-1:0],
                         directed_plan[i].n_typed, directed_plan[i].b0, directed_plan[i].b1);
      end
    end
    settle_block();

    // Random phases: each picks a setting, then sends a run of coefficients.
    while (random_sent < RANDOM_ITEMS) begin
      quiet = (random_sent >= RANDOM_ITEMS - QUIET_TAIL);
      tx_gaps = !quiet && ($urandom_range(0, 2) != 0);
      rx_gaps = !quiet && ($urandom_range(0, 2) != 0);
      case ($urandom_range(0, 9))
        0: q_pick = 14'd2;
        1: q_pick = 14'h3FFF;
        2: q_pick = 14'd0;
        3: q_pick = 14'd1;
        4: q_pick = 14'd3329;
        default: q_pick = 14'($urandom_range(2, 16383));
      endcase
      fmt_pick = 2'($urandom_range(0, 3));
      remaining = COEFF_COUNT - coeff_pos;
      hold_phase = 1'b0;
      // Steer phases onto the polynomial end, mostly in raw format, to reach the tail cases.
      if (remaining == 1) begin
        length = 1;
        if ($urandom_range(0, 3) != 0) fmt_pick = ccp_pkg::FMT_RAW;
      end else if (!hold_done && !quiet && random_sent > 400) begin
        hold_phase = 1'b1;
        hold_done = 1'b1;
        fmt_pick = ccp_pkg::FMT_RAW;
        length = 40;
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        length = remaining - 1;
      end else begin
        length = $urandom_range(1, 60);
      end
      // Keep each phase inside its part of the run.
      if (quiet) begin
        if (length > RANDOM_ITEMS - random_sent) length = RANDOM_ITEMS - random_sent;
      end else if (length > RANDOM_ITEMS - QUIET_TAIL - random_sent) begin
        length = RANDOM_ITEMS - QUIET_TAIL - random_sent;
      end

      write_register(ADDR_MODULUS, {18'($urandom), q_pick});
      write_register(ADDR_FORMAT, {30'($urandom), fmt_pick});
      check_registers();
      phase_count++;
      if (hold_phase) hold_off_request = 1'b1;

      repeat (length) begin
        case ($urandom_range(0, 7))
          0: x = '0;
          1: x = '1;
          default: x = 14'($urandom);
        endcase
        send_coefficient(x, PREDICTED, 8'h00, 8'h00);
        random_sent++;
      end
      settle_block();
    end

    $display("Run covered %0d coefficients over %0d random settings; %0d bytes checked.",
             coeffs_sent, phase_count, bytes_checked);
    $display("Polynomial ends seen: %0d; long output hold-off applied: %0b.",
             polys_done, hold_done);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #6000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/ccp_pkg.sv
rtl/core/ccp_front.sv
rtl/core/ccp_fifo.sv
rtl/core/ccp_divider.sv
rtl/core/ccp_back.sv
rtl/core/coefficient_compress_pack.sv
bench/tb_coefficient_compress_pack.sv
